@@ rtl/dad_pkg.sv @@
`default_nettype none
package dad_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned COUNT_W  = 16;
  // working width: day numbers up to 366 + 65535, years past 65535
  localparam int unsigned ACC_W    = 17;
  localparam int unsigned CYCLE_W  = 9;
  localparam int unsigned STEP_W   = 3;

  localparam logic [YEAR_W-1:0]  FIRST_YEAR   = YEAR_W'(1601);
  localparam logic [YEAR_W-1:0]  YEAR_SAT     = '1;
  localparam logic [ACC_W-1:0]   CYCLE_LEN    = ACC_W'(400);
  localparam logic [CYCLE_W-1:0] CYCLE_LAST   = CYCLE_W'(399);
  localparam logic [CYCLE_W-1:0] CENT_1       = CYCLE_W'(100);
  localparam logic [CYCLE_W-1:0] CENT_2       = CYCLE_W'(200);
  localparam logic [CYCLE_W-1:0] CENT_3       = CYCLE_W'(300);
  localparam logic [ACC_W-1:0]   LEAP_YEAR_LEN = ACC_W'(366);
  localparam logic [ACC_W-1:0]   NORM_YEAR_LEN = ACC_W'(365);
  localparam logic [MONTH_W-1:0] JAN          = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB          = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DEC          = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_SAT      = DAY_W'(31);
  localparam logic [STEP_W-1:0]  MOD_STEP_TOP = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DOY   = 7'b0001000,
    S_YEAR  = 7'b0010000,
    S_MON   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             ge;
    logic             gt;
  } alu_res_t;

  // leap test from the year modulo 400
  function automatic logic is_leap(input logic [CYCLE_W-1:0] ymod);
    logic l;
    l = (ymod[1:0] == 2'b00) && (ymod != CENT_1) && (ymod != CENT_2) && (ymod != CENT_3);
    return l;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:    n = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4:    n = DAY_W'(30);
      4'd6:    n = DAY_W'(30);
      4'd9:    n = DAY_W'(30);
      4'd11:   n = DAY_W'(30);
      default: n = DAY_W'(31);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dad_alu.sv @@
`default_nettype none
module dad_alu (
  input  wire dad_pkg::alu_op_t         op,
  input  wire logic [dad_pkg::ACC_W-1:0] a,
  input  wire logic [dad_pkg::ACC_W-1:0] b,
  output dad_pkg::alu_res_t             y
);

  logic [dad_pkg::ACC_W:0] diff;
  logic [dad_pkg::ACC_W:0] sum;

  assign diff = {1'b0, a} - {1'b0, b};
  assign sum  = {1'b0, a} + {1'b0, b};

  always_comb begin
    y.ge  = ~diff[dad_pkg::ACC_W];
    y.gt  = ~diff[dad_pkg::ACC_W] && (diff[dad_pkg::ACC_W-1:0] != '0);
    y.res = (op == dad_pkg::ALU_ADD) ? sum[dad_pkg::ACC_W-1:0]
                                     : diff[dad_pkg::ACC_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/date_add_days.sv @@
// Gregorian date plus a non-negative day count.
// Input stream: one transaction carries a start date and a day count.
// Result stream: one transaction per input with the advanced date and flags
// (out_tuser bit 0 invalid start date, bit 1 result year beyond 65535).
// An invalid date returns zeros; a year overflow saturates to 31.12.65535.
// One shared add/subtract-compare unit does all acc_r arithmetic in sequence:
//   year modulo 400 (shift-subtract of 400 << k, k = 7..0)
//   validity check (an invalid date goes straight to the result)
//   day of year build plus the count add (one month per cycle)
//   whole years taken off, one per cycle, plus the exit check
//   month walk, one per cycle
//   result register load
// The year loop dominates the run time. in_tready is high only while idle, so
// the next transaction is taken at the earliest in the cycle after the result
// is loaded.
// A finished result waits in the output register until out_tready; the sequencer
// holds in its final state only while an earlier result still waits there.
// Synchronous active-low reset returns to idle and drops out_tvalid.
`default_nettype none
module date_add_days (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [47:0] in_tdata,  // start_day, start_month, start_year, days_to_add
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // result_day, result_month, result_year
  output logic [1:0] out_tuser   // input_invalid, year_overflow
);

  localparam int unsigned AW = dad_pkg::ACC_W;

  dad_pkg::state_t state_r, state_nxt;
  logic [dad_pkg::DAY_W-1:0]   d_r, d_nxt;
  logic [dad_pkg::MONTH_W-1:0] m_r, m_nxt;
  logic [AW-1:0]               yr_r, yr_nxt;
  logic [dad_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]               acc_r, acc_nxt;
  logic [dad_pkg::CYCLE_W-1:0] ymod_r, ymod_nxt;
  logic [dad_pkg::STEP_W-1:0]  k_r, k_nxt;
  logic [dad_pkg::MONTH_W-1:0] mon_r, mon_nxt;
  logic                        inval_r, inval_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [31:0]                 odata_r, odata_nxt;
  logic [1:0]                  ouser_r, ouser_nxt;

  dad_pkg::alu_op_t  alu_op;
  logic [AW-1:0]     alu_b;
  dad_pkg::alu_res_t alu_y;
  logic              leap;
  logic [dad_pkg::DAY_W-1:0] mlen_in, mlen_cur;
  logic              bad;

  dad_alu u_alu (
    .op (alu_op),
    .a  (acc_r),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign leap     = dad_pkg::is_leap(ymod_r);
  assign mlen_in  = dad_pkg::month_len(m_r, leap);
  assign mlen_cur = dad_pkg::month_len(mon_r, leap);
  assign bad = (yr_r[dad_pkg::YEAR_W-1:0] < dad_pkg::FIRST_YEAR) || (m_r == '0)
            || (m_r > dad_pkg::DEC) || (d_r == '0) || (d_r > mlen_in);

  assign in_tready  = (state_r == dad_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    m_nxt      = m_r;
    yr_nxt     = yr_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    ymod_nxt   = ymod_r;
    k_nxt      = k_r;
    mon_nxt    = mon_r;
    inval_nxt  = inval_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    ovalid_nxt = ovalid_r && !out_tready;
    alu_op     = dad_pkg::ALU_SUB;
    alu_b      = '0;
    case (state_r)
      dad_pkg::S_IDLE: begin
        if (in_tvalid) begin
          d_nxt     = in_tdata[4:0];
          m_nxt     = in_tdata[8:5];
          yr_nxt    = {1'b0, in_tdata[24:9]};
          cnt_nxt   = in_tdata[40:25];
          acc_nxt   = {1'b0, in_tdata[24:9]};
          k_nxt     = dad_pkg::MOD_STEP_TOP;
          state_nxt = dad_pkg::S_MOD;
        end
      end
      dad_pkg::S_MOD: begin
        alu_b = dad_pkg::CYCLE_LEN << k_r;
        if (alu_y.ge) begin
          acc_nxt = alu_y.res;
        end
        k_nxt = k_r - 1'b1;
        if (k_r == '0) begin
          ymod_nxt  = alu_y.ge ? alu_y.res[dad_pkg::CYCLE_W-1:0]
                               : acc_r[dad_pkg::CYCLE_W-1:0];
          state_nxt = dad_pkg::S_CHECK;
        end
      end
      dad_pkg::S_CHECK: begin
        inval_nxt = bad;
        acc_nxt   = AW'(d_r);
        mon_nxt   = dad_pkg::JAN;
        state_nxt = bad ? dad_pkg::S_DONE : dad_pkg::S_DOY;
      end
      dad_pkg::S_DOY: begin
        alu_op  = dad_pkg::ALU_ADD;
        acc_nxt = alu_y.res;
        if (mon_r == m_r) begin
          alu_b     = AW'(cnt_r);
          state_nxt = dad_pkg::S_YEAR;
        end else begin
          alu_b   = AW'(mlen_cur);
          mon_nxt = mon_r + 1'b1;
        end
      end
      dad_pkg::S_YEAR: begin
        alu_b = leap ? dad_pkg::LEAP_YEAR_LEN : dad_pkg::NORM_YEAR_LEN;
        if (alu_y.gt) begin
          acc_nxt  = alu_y.res;
          yr_nxt   = yr_r + 1'b1;
          ymod_nxt = (ymod_r == dad_pkg::CYCLE_LAST) ? '0 : ymod_r + 1'b1;
        end else begin
          mon_nxt   = dad_pkg::JAN;
          state_nxt = dad_pkg::S_MON;
        end
      end
      dad_pkg::S_MON: begin
        alu_b = AW'(mlen_cur);
        if ((mon_r < dad_pkg::DEC) && alu_y.gt) begin
          acc_nxt = alu_y.res;
          mon_nxt = mon_r + 1'b1;
        end else begin
          state_nxt = dad_pkg::S_DONE;
        end
      end
      dad_pkg::S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = dad_pkg::S_IDLE;
          if (inval_r) begin
            odata_nxt = '0;
            ouser_nxt = 2'b01;
          end else if (yr_r[AW-1]) begin
            odata_nxt = {7'b0, dad_pkg::YEAR_SAT, dad_pkg::DEC, dad_pkg::DAY_SAT};
            ouser_nxt = 2'b10;
          end else begin
            odata_nxt = {7'b0, yr_r[dad_pkg::YEAR_W-1:0], mon_r, acc_r[dad_pkg::DAY_W-1:0]};
            ouser_nxt = 2'b00;
          end
        end
      end
      default: begin
        state_nxt = dad_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dad_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    m_r     <= m_nxt;
    yr_r    <= yr_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    ymod_r  <= ymod_nxt;
    k_r     <= k_nxt;
    mon_r   <= mon_nxt;
    inval_r <= inval_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/dad_checker.sv @@
`default_nettype none
module dad_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0 && !out_tuser[1])
    else $error("invalid date result not cleared");

  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[4:0] == 5'd31 && out_tdata[8:5] == 4'd12 && out_tdata[24:9] == 16'hFFFF)
    else $error("overflow result not saturated");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
